>>> rtl/uart_move_command_parser_assert.svh
// Assertion macros for the move command parser.
// Used by the RTL files that carry concurrent assertions; no other dependency.
`ifndef UART_MOVE_COMMAND_PARSER_ASSERT_SVH
`define UART_MOVE_COMMAND_PARSER_ASSERT_SVH

// Check that post holds in the same cycle as pre
`define UMCP_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("umcp: same-cycle check failed");

// Check that post holds in the cycle after pre
`define UMCP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("umcp: next-cycle check failed");

`endif

>>> rtl/umcp_pkg.sv
// Shared constants and types of the move command parser.
// No dependencies; used by all RTL modules.
`default_nettype none

package umcp_pkg;

   // Longest line held before parsing restarts
   localparam int LINE_MAX = 64;
   localparam int POS_W    = $clog2(LINE_MAX);

   // Line record queue between parser and drive stage
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Result status codes
   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_BAD = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_GAIN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_GAIN = 1'd1;

   // Gain defaults after reset, Q16
   localparam logic [15:0] MOVE_GAIN_RESET = 16'd459;
   localparam logic [15:0] TURN_GAIN_RESET = 16'd9830;

   // One finished line as handed to the drive stage
   typedef struct packed {
      logic [1:0]         status;
      logic signed [15:0] turn_value;
      logic signed [15:0] move_value;
   } line_rec_type;

endpackage

`default_nettype wire

>>> rtl/umcp_req_if.sv
// Byte input channel of the move command parser.
// No dependencies.
`default_nettype none

interface umcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/umcp_rsp_if.sv
// Result channel of the move command parser.
// No dependencies.
`default_nettype none

interface umcp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [15:0] turn_value;
   logic signed [15:0] move_value;
   logic signed [31:0] turn_drive;
   logic signed [31:0] move_drive;

   modport source (output valid, output status, output turn_value, output move_value,
                   output turn_drive, output move_drive, input ready);
   modport sink   (input valid, input status, input turn_value, input move_value,
                   input turn_drive, input move_drive, output ready);
endinterface

`default_nettype wire

>>> rtl/uart_move_command_parser.sv
// Move command parser: one received byte per cycle, one result per newline.
// A line record passes the queue, multiply stage and output register.
// Throughput: one byte per cycle; results one per cycle while ready is high.
// The two-entry line queue stalls every input byte while it is full.
// Reset (synchronous) clears the parse, the queue and the pipeline and
// restores both gains to their defaults.
`default_nettype none

module uart_move_command_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   umcp_req_if.sink                            req_chan,
   umcp_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_write_enable,
   input  wire logic [umcp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]                    csr_write_data
);

   logic                   q_push;
   logic                   q_pop;
   logic                   q_full;
   logic                   q_empty;
   umcp_pkg::line_rec_type q_push_rec;
   umcp_pkg::line_rec_type q_pop_rec;

   // Parse bytes into line records
   umcp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_rec    (q_push_rec)
   );

   // Decouple parser from drive stage
   umcp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_push_rec),
      .full     (q_full),
      .pop      (q_pop),
      .pop_rec  (q_pop_rec),
      .empty    (q_empty)
   );

   // Compute drives and present results
   umcp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_empty          (q_empty),
      .q_rec            (q_pop_rec),
      .q_pop            (q_pop),
      .rsp_chan         (rsp_chan)
   );

endmodule

`default_nettype wire

>>> rtl/umcp_front.sv
// Byte parser: folds case, matches "move " and two signed integers on the fly,
// and pushes one line record per newline. Depends on umcp_pkg and umcp_req_if.
`default_nettype none

module umcp_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   umcp_req_if.sink                   req_chan,
   input  wire logic                  q_full,
   output logic                       q_push,
   output umcp_pkg::line_rec_type     q_rec
);

   // Parse phases
   localparam logic [3:0] PH_M     = 4'd0;
   localparam logic [3:0] PH_O     = 4'd1;
   localparam logic [3:0] PH_V     = 4'd2;
   localparam logic [3:0] PH_E     = 4'd3;
   localparam logic [3:0] PH_SPACE = 4'd4;
   localparam logic [3:0] PH_PRE1  = 4'd5;
   localparam logic [3:0] PH_SIGN1 = 4'd6;
   localparam logic [3:0] PH_DIG1  = 4'd7;
   localparam logic [3:0] PH_PRE2  = 4'd8;
   localparam logic [3:0] PH_SIGN2 = 4'd9;
   localparam logic [3:0] PH_DIG2  = 4'd10;
   localparam logic [3:0] PH_OK    = 4'd11;
   localparam logic [3:0] PH_BAD   = 4'd12;

   // Characters
   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_SP    = 8'd32;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_PLUS  = 8'd43;

   localparam logic [umcp_pkg::POS_W-1:0] POS_LAST =
      umcp_pkg::POS_W'(umcp_pkg::LINE_MAX - 1);

   logic [umcp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [3:0]                 phase_ff, phase_in;
   logic [15:0]                first_ff, first_in;
   logic [15:0]                second_ff, second_in;
   logic [1:0]                 sign_ff, sign_in;
   logic                       sat_ff, sat_in;

   logic        accept;
   logic [7:0]  ch;
   logic        ch_space;
   logic        ch_digit;
   logic        second_grp;
   logic        fresh;
   logic [15:0] acc_base;
   logic        acc_neg;
   logic [18:0] acc_next;
   logic [18:0] acc_limit;
   logic        acc_over;
   logic [15:0] acc_val;
   logic        line_ok;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && req_chan.ready;

   // Fold case and classify the byte
   always_comb begin
      ch = req_chan.rx_byte;
      if (ch >= 8'd65 && ch <= 8'd90) begin
         ch = ch + 8'd32;
      end
      ch_space = (ch == 8'd32) || (ch == 8'd9) || (ch == 8'd11) ||
                 (ch == 8'd12) || (ch == 8'd13);
      ch_digit = (ch >= 8'd48) && (ch <= 8'd57);
   end

   // Shared digit accumulator: acc * 10 + digit, clamped at the signed limit
   always_comb begin
      second_grp = (phase_ff == PH_PRE2) || (phase_ff == PH_SIGN2) || (phase_ff == PH_DIG2);
      fresh      = (phase_ff == PH_PRE1) || (phase_ff == PH_PRE2);
      acc_base   = fresh ? 16'd0 : (second_grp ? second_ff : first_ff);
      acc_neg    = fresh ? 1'b0 : (second_grp ? sign_ff[1] : sign_ff[0]);
      acc_next   = {acc_base, 3'b000} + {2'b00, acc_base, 1'b0} + {15'd0, ch[3:0]};
      acc_limit  = acc_neg ? 19'd32768 : 19'd32767;
      acc_over   = acc_next > acc_limit;
      acc_val    = acc_over ? acc_limit[15:0] : acc_next[15:0];
   end

   // Advance the parse on each accepted byte
   always_comb begin
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      sign_in   = sign_ff;
      sat_in    = sat_ff;
      if (accept) begin
         if (req_chan.rx_byte == CH_NL || pos_ff >= POS_LAST) begin
            // End of line or overlong line: restart
            pos_in    = '0;
            phase_in  = PH_M;
            first_in  = 16'd0;
            second_in = 16'd0;
            sign_in   = 2'b00;
            sat_in    = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
            case (phase_ff)
               PH_M:     phase_in = (ch == 8'd109) ? PH_O : PH_BAD;
               PH_O:     phase_in = (ch == 8'd111) ? PH_V : PH_BAD;
               PH_V:     phase_in = (ch == 8'd118) ? PH_E : PH_BAD;
               PH_E:     phase_in = (ch == 8'd101) ? PH_SPACE : PH_BAD;
               PH_SPACE: phase_in = (ch == CH_SP) ? PH_PRE1 : PH_BAD;
               PH_PRE1, PH_PRE2: begin
                  if (ch_space) begin
                     phase_in = phase_ff;
                  end else if (ch == CH_MINUS) begin
                     if (second_grp) begin
                        sign_in[1] = 1'b1;
                     end else begin
                        sign_in[0] = 1'b1;
                     end
                     phase_in = second_grp ? PH_SIGN2 : PH_SIGN1;
                  end else if (ch == CH_PLUS) begin
                     phase_in = second_grp ? PH_SIGN2 : PH_SIGN1;
                  end else if (ch_digit) begin
                     if (second_grp) begin
                        second_in = acc_val;
                     end else begin
                        first_in = acc_val;
                     end
                     phase_in = second_grp ? PH_DIG2 : PH_DIG1;
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
               PH_SIGN1, PH_DIG1: begin
                  if (ch_digit) begin
                     first_in = acc_val;
                     sat_in   = sat_ff | acc_over;
                     phase_in = PH_DIG1;
                  end else if (phase_ff == PH_SIGN1) begin
                     phase_in = PH_BAD;
                  end else if (ch_space) begin
                     phase_in = PH_PRE2;
                  end else if (ch == CH_MINUS) begin
                     sign_in[1] = 1'b1;
                     phase_in   = PH_SIGN2;
                  end else if (ch == CH_PLUS) begin
                     phase_in = PH_SIGN2;
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
               PH_SIGN2, PH_DIG2: begin
                  if (ch_digit) begin
                     second_in = acc_val;
                     sat_in    = sat_ff | acc_over;
                     phase_in  = PH_DIG2;
                  end else begin
                     phase_in = (phase_ff == PH_DIG2) ? PH_OK : PH_BAD;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= PH_M;
         first_ff  <= 16'd0;
         second_ff <= 16'd0;
         sign_ff   <= 2'b00;
         sat_ff    <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         sign_ff   <= sign_in;
         sat_ff    <= sat_in;
      end
   end

   // Build the line record on newline
   assign line_ok = (phase_ff == PH_DIG2) || (phase_ff == PH_OK);
   assign q_push  = accept && (req_chan.rx_byte == CH_NL);

   always_comb begin
      if (line_ok) begin
         q_rec.status     = sat_ff ? umcp_pkg::ST_SAT : umcp_pkg::ST_OK;
         q_rec.turn_value = sign_ff[0] ? $signed(16'd0 - first_ff) : $signed(first_ff);
         q_rec.move_value = sign_ff[1] ? $signed(16'd0 - second_ff) : $signed(second_ff);
      end else begin
         q_rec.status     = umcp_pkg::ST_BAD;
         q_rec.turn_value = 16'sd0;
         q_rec.move_value = 16'sd0;
      end
   end

endmodule

`default_nettype wire

>>> rtl/umcp_queue.sv
// Short queue of line records between the parser and the drive stage.
// Depends on umcp_pkg and the assertion macro header.
`default_nettype none
`include "uart_move_command_parser_assert.svh"

module umcp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire umcp_pkg::line_rec_type push_rec,
   output logic                        full,
   input  wire logic                   pop,
   output umcp_pkg::line_rec_type      pop_rec,
   output logic                        empty
);

   umcp_pkg::line_rec_type slot_ff [umcp_pkg::QUEUE_DEPTH];

   logic [umcp_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [umcp_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [umcp_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full    = count_ff == umcp_pkg::QUEUE_CNT_W'(umcp_pkg::QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign pop_rec = slot_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == umcp_pkg::QUEUE_PTR_W'(umcp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == umcp_pkg::QUEUE_PTR_W'(umcp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed record
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

   `UMCP_ASSERT_NOW(a_no_overflow, clock, reset, push, !full)
   `UMCP_ASSERT_NOW(a_no_underflow, clock, reset, pop, !empty)
   `UMCP_ASSERT_NEXT(a_push_fills, clock, reset, push, !empty)
   `UMCP_ASSERT_NEXT(a_pop_frees, clock, reset, pop && !push, !full)

endmodule

`default_nettype wire

>>> rtl/umcp_back.sv
// Drive stage: holds the gains, multiplies line values by them and negates,
// then presents the result. Depends on umcp_pkg and umcp_rsp_if.
`default_nettype none

module umcp_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [umcp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]                   csr_write_data,
   input  wire logic                          q_empty,
   input  wire umcp_pkg::line_rec_type        q_rec,
   output logic                               q_pop,
   umcp_rsp_if.source                         rsp_chan
);

   logic [15:0] move_gain_ff, move_gain_in;
   logic [15:0] turn_gain_ff, turn_gain_in;

   logic                   mul_valid_ff, mul_valid_in;
   umcp_pkg::line_rec_type mul_rec_ff;
   logic [31:0]            turn_prod_ff;
   logic [31:0]            move_prod_ff;

   logic               out_valid_ff, out_valid_in;
   logic [1:0]         out_status_ff;
   logic signed [15:0] out_turn_value_ff;
   logic signed [15:0] out_move_value_ff;
   logic [31:0]        out_turn_drive_ff;
   logic [31:0]        out_move_drive_ff;

   logic               out_adv;
   logic               mul_adv;
   logic signed [33:0] turn_prod;
   logic signed [33:0] move_prod;

   // Gain registers
   always_comb begin
      move_gain_in = move_gain_ff;
      turn_gain_in = turn_gain_ff;
      if (csr_write_enable) begin
         case (csr_index)
            umcp_pkg::CSR_MOVE_GAIN: move_gain_in = csr_write_data;
            umcp_pkg::CSR_TURN_GAIN: turn_gain_in = csr_write_data;
            default: begin
               move_gain_in = move_gain_ff;
               turn_gain_in = turn_gain_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         move_gain_ff <= umcp_pkg::MOVE_GAIN_RESET;
         turn_gain_ff <= umcp_pkg::TURN_GAIN_RESET;
      end else begin
         move_gain_ff <= move_gain_in;
         turn_gain_ff <= turn_gain_in;
      end
   end

   // Pipeline flow: output register frees when empty or taken
   assign out_adv      = !out_valid_ff || rsp_chan.ready;
   assign mul_adv      = !mul_valid_ff || out_adv;
   assign q_pop        = mul_adv && !q_empty;
   assign mul_valid_in = mul_adv ? !q_empty : mul_valid_ff;
   assign out_valid_in = out_adv ? mul_valid_ff : out_valid_ff;

   // Signed value times unsigned gain
   assign turn_prod = $signed({q_rec.turn_value[15], q_rec.turn_value}) *
                      $signed({1'b0, turn_gain_ff});
   assign move_prod = $signed({q_rec.move_value[15], q_rec.move_value}) *
                      $signed({1'b0, move_gain_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Multiply stage
   always_ff @(posedge clock) begin
      if (q_pop) begin
         mul_rec_ff   <= q_rec;
         turn_prod_ff <= turn_prod[31:0];
         move_prod_ff <= move_prod[31:0];
      end
   end

   // Output register: negate the products
   always_ff @(posedge clock) begin
      if (out_adv && mul_valid_ff) begin
         out_status_ff     <= mul_rec_ff.status;
         out_turn_value_ff <= mul_rec_ff.turn_value;
         out_move_value_ff <= mul_rec_ff.move_value;
         out_turn_drive_ff <= 32'd0 - turn_prod_ff;
         out_move_drive_ff <= 32'd0 - move_prod_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.status     = out_status_ff;
   assign rsp_chan.turn_value = out_turn_value_ff;
   assign rsp_chan.move_value = out_move_value_ff;
   assign rsp_chan.turn_drive = $signed(out_turn_drive_ff);
   assign rsp_chan.move_drive = $signed(out_move_drive_ff);

endmodule

`default_nettype wire

>>> tb/tb_uart_move_command_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench for the move command parser: byte streams in, line results out.
// Depends on umcp_pkg, umcp_req_if, umcp_rsp_if and the uart_move_command_parser RTL.

module tb_uart_move_command_parser;

   // Parse phases of the line predictor
   typedef enum logic [3:0] {
      WANT_M, WANT_O, WANT_V, WANT_E, WANT_GAP,
      LEAD1, SIGN1, DIGITS1, LEAD2, SIGN2, DIGITS2, TAIL, REJECT
   } parse_phase_type;

   // One expected line result
   typedef struct packed {
      logic [1:0]         status;
      logic signed [15:0] turn_value;
      logic signed [15:0] move_value;
      logic signed [31:0] turn_drive;
      logic signed [31:0] move_drive;
   } move_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [umcp_pkg::CSR_IDX_W-1:0] csr_index;
   logic [15:0] csr_write_data;

   umcp_req_if req_chan ();
   umcp_rsp_if rsp_chan ();

   uart_move_command_parser uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state: gains and the line being parsed
   logic [15:0]     gain_move;
   logic [15:0]     gain_turn;
   int              ln_len;
   parse_phase_type ln_phase;
   int unsigned     ln_mag1;
   int unsigned     ln_mag2;
   bit              ln_neg1;
   bit              ln_neg2;
   bit              ln_clipped;

   move_result_type expected_lines[$];
   int              bad_results = 0;

   // Stimulus controls
   bit          feed_idle = 1'b0;
   bit          drain_idle = 1'b0;
   int          rsp_hold_cycles = 0;
   logic [7:0]  line_buf[$];
   logic [7:0]  blank_chars[5] = '{8'd32, 8'd9, 8'd11, 8'd12, 8'd13};
   string       edge_numbers[4] = '{"32767", "32768", "32769", "0"};

   function automatic bit is_blank(logic [7:0] c);
      return c == 8'd32 || c == 8'd9 || c == 8'd11 || c == 8'd12 || c == 8'd13;
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= 8'd48 && c <= 8'd57;
   endfunction

   // Append one decimal digit to a magnitude, clamp at the signed 16-bit limit
   function automatic int unsigned add_digit_sat(int unsigned acc, logic [7:0] c, bit neg);
      int unsigned cap;
      int unsigned nxt;
      cap = neg ? 32'd32768 : 32'd32767;
      nxt = acc * 10 + (int'(c) - 48);
      if (nxt > cap) begin
         ln_clipped = 1'b1;
         return cap;
      end
      return nxt;
   endfunction

   function automatic void restart_line();
      ln_len     = 0;
      ln_phase   = WANT_M;
      ln_mag1    = 0;
      ln_mag2    = 0;
      ln_neg1    = 1'b0;
      ln_neg2    = 1'b0;
      ln_clipped = 1'b0;
   endfunction

   // Advance the parse by one folded character
   function automatic void advance_parse(logic [7:0] c);
      case (ln_phase)
         WANT_M: ln_phase = (c == "m") ? WANT_O : REJECT;
         WANT_O: ln_phase = (c == "o") ? WANT_V : REJECT;
         WANT_V: ln_phase = (c == "v") ? WANT_E : REJECT;
         WANT_E: ln_phase = (c == "e") ? WANT_GAP : REJECT;
         WANT_GAP: ln_phase = (c == 8'd32) ? LEAD1 : REJECT;
         LEAD1: begin
            if (!is_blank(c)) begin
               if (c == "-") begin
                  ln_neg1  = 1'b1;
                  ln_phase = SIGN1;
               end else if (c == "+") begin
                  ln_phase = SIGN1;
               end else if (is_digit(c)) begin
                  ln_mag1  = add_digit_sat(0, c, 1'b0);
                  ln_phase = DIGITS1;
               end else begin
                  ln_phase = REJECT;
               end
            end
         end
         SIGN1, DIGITS1: begin
            if (is_digit(c)) begin
               ln_mag1  = add_digit_sat(ln_mag1, c, ln_neg1);
               ln_phase = DIGITS1;
            end else if (ln_phase == SIGN1) begin
               ln_phase = REJECT;
            end else if (is_blank(c)) begin
               ln_phase = LEAD2;
            end else if (c == "-") begin
               ln_neg2  = 1'b1;
               ln_phase = SIGN2;
            end else if (c == "+") begin
               ln_phase = SIGN2;
            end else begin
               ln_phase = REJECT;
            end
         end
         LEAD2: begin
            if (!is_blank(c)) begin
               if (c == "-") begin
                  ln_neg2  = 1'b1;
                  ln_phase = SIGN2;
               end else if (c == "+") begin
                  ln_phase = SIGN2;
               end else if (is_digit(c)) begin
                  ln_mag2  = add_digit_sat(0, c, 1'b0);
                  ln_phase = DIGITS2;
               end else begin
                  ln_phase = REJECT;
               end
            end
         end
         SIGN2, DIGITS2: begin
            if (is_digit(c)) begin
               ln_mag2  = add_digit_sat(ln_mag2, c, ln_neg2);
               ln_phase = DIGITS2;
            end else begin
               ln_phase = (ln_phase == DIGITS2) ? TAIL : REJECT;
            end
         end
         default: ;
      endcase
   endfunction

   // Update the predictor with one accepted byte; a newline queues a result
   function automatic void predict_byte(logic [7:0] b);
      logic [7:0]      c;
      longint          tv;
      longint          mv;
      longint          td;
      longint          md;
      move_result_type r;
      if (b != 8'd10) begin
         if (ln_len < umcp_pkg::LINE_MAX - 1) begin
            ln_len++;
            c = b;
            if (c >= "A" && c <= "Z") c = c + 8'd32;
            advance_parse(c);
         end else begin
            restart_line();
         end
      end else begin
         r = '0;
         if (ln_phase == DIGITS2 || ln_phase == TAIL) begin
            tv = ln_neg1 ? -longint'(ln_mag1) : longint'(ln_mag1);
            mv = ln_neg2 ? -longint'(ln_mag2) : longint'(ln_mag2);
            td = -tv * longint'(gain_turn);
            md = -mv * longint'(gain_move);
            r.status     = ln_clipped ? umcp_pkg::ST_SAT : umcp_pkg::ST_OK;
            r.turn_value = tv[15:0];
            r.move_value = mv[15:0];
            r.turn_drive = td[31:0];
            r.move_drive = md[31:0];
         end else begin
            r.status = umcp_pkg::ST_BAD;
         end
         expected_lines.push_back(r);
         restart_line();
      end
   endfunction

   // Send one byte item, with a random gap when the sender idles
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = feed_idle ? $urandom_range(0, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.rx_byte = b;
      do @(posedge clock); while (!req_chan.ready);
      predict_byte(b);
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_byte(line_buf[i]);
      line_buf = {};
   endtask

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   task automatic send_text(input string s);
      push_text(s);
      send_line();
   endtask

   // Drop valid and hold until every expected result has come
   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
   endtask

   // Write both gains while the block is idle
   task automatic write_gains(input logic [15:0] move_g, input logic [15:0] turn_g);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = umcp_pkg::CSR_MOVE_GAIN;
      csr_write_data   = move_g;
      @(negedge clock);
      csr_index        = umcp_pkg::CSR_TURN_GAIN;
      csr_write_data   = turn_g;
      @(negedge clock);
      csr_write_enable = 1'b0;
      gain_move = move_g;
      gain_turn = turn_g;
   endtask

   function automatic logic [7:0] any_but_newline();
      logic [7:0] b;
      do b = $urandom_range(0, 255); while (b == 8'd10);
      return b;
   endfunction

   function automatic void push_blanks(int lo, int hi);
      int n;
      n = $urandom_range(lo, hi);
      repeat (n) line_buf.push_back(blank_chars[$urandom_range(0, 4)]);
   endfunction

   // Signed number: optional sign, boundary values or random digit runs
   function automatic void push_signed_number(int sgn);
      int nd;
      if (sgn == 1) line_buf.push_back("+");
      if (sgn == 2) line_buf.push_back("-");
      if ($urandom_range(0, 4) == 0) begin
         push_text(edge_numbers[$urandom_range(0, 3)]);
      end else begin
         nd = $urandom_range(1, 6);
         repeat (nd) line_buf.push_back(8'd48 + 8'($urandom_range(0, 9)));
      end
   endfunction

   // Build one random line: mostly well-formed, some broken, some noise
   function automatic void compose_random_line();
      string kw;
      int    kind;
      int    sgn2;
      int    n;
      kw   = "move";
      kind = $urandom_range(0, 15);
      if (kind == 13) begin
         n = $urandom_range(0, 20);
         repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
         line_buf.push_back(8'd10);
         return;
      end
      if (kind == 14) begin
         n = $urandom_range(55, 70);
         repeat (n) line_buf.push_back(any_but_newline());
      end
      for (int i = 0; i < 4; i++)
         line_buf.push_back($urandom_range(0, 1) ? kw[i] - 8'd32 : kw[i]);
      line_buf.push_back(8'd32);
      push_blanks(0, 3);
      push_signed_number($urandom_range(0, 2));
      sgn2 = $urandom_range(0, 2);
      if (sgn2 == 0 || $urandom_range(0, 1)) push_blanks(1, 3);
      push_signed_number(sgn2);
      case ($urandom_range(0, 3))
         1: begin
            push_blanks(1, 2);
            n = $urandom_range(1, 6);
            repeat (n) line_buf.push_back(8'($urandom_range(33, 126)));
         end
         2: begin
            line_buf.push_back(8'd0);
            n = $urandom_range(0, 5);
            repeat (n) line_buf.push_back(any_but_newline());
         end
         3: begin
            n = $urandom_range(1, 5);
            repeat (n) line_buf.push_back(any_but_newline());
         end
         default: ;
      endcase
      n = $urandom_range(0, line_buf.size() - 1);
      case (kind)
         10, 11: line_buf[n] = 8'($urandom_range(0, 255));
         12: line_buf.delete(n);
         15: while (line_buf.size() > n) line_buf.delete(line_buf.size() - 1);
         default: ;
      endcase
      line_buf.push_back(8'd10);
   endfunction

   // Lines under the reset gains
   task automatic test_reset_gains();
      send_text("move 100 -200\n");
      send_text("MOVE -32768 32767\n");
   endtask

   // Syntax rules: case folding, blanks, signs, rejects, saturation
   task automatic test_syntax();
      send_text("move 12 -34\n");
      send_text("MoVe 32768 -32769\n");
      send_text("move 99999 1\n");
      send_text("move\0111 2\n");
      send_text("move  \011-5\013\014+6 trailing\n");
      send_text("move 7-8\n");
      send_text("move 7+8\015\n");
      send_text("move - 5 6\n");
      send_text("move 5 -\n");
      send_text("move 5\n");
      send_text("\n");
      send_text("xmove 1 2\n");
      send_text("move @1 2\n");
      send_text("move 0 0\n");
   endtask

   // Zero byte ends the text only after the second number
   task automatic test_zero_byte();
      push_text("move 5 6");
      line_buf.push_back(8'd0);
      push_text("junk");
      line_buf.push_back(8'hff);
      push_text("\n");
      send_line();
      push_text("mo");
      line_buf.push_back(8'd0);
      push_text("ve 1 2\n");
      send_line();
   endtask

   // Lines at and beyond the length limit
   task automatic test_long_lines();
      // 63 bytes then newline: still parsed
      push_text("move 3 4");
      repeat (55) line_buf.push_back(8'd32);
      push_text("\n");
      send_line();
      // the 64th byte restarts the parse, the rest is a clean line
      repeat (64) line_buf.push_back("x");
      push_text("move 1 -2\n");
      send_line();
      // restart in trailing text leaves garbage
      push_text("move 9 9");
      repeat (60) line_buf.push_back(8'd32);
      push_text("\n");
      send_line();
   endtask

   // Gain extremes and a random setting
   task automatic test_gain_settings();
      write_gains(16'd0, 16'd0);
      send_text("move -32768 32767\n");
      write_gains(16'hffff, 16'hffff);
      send_text("move -32768 32767\n");
      send_text("move 32767 -32768\n");
      write_gains(16'hffff, 16'd0);
      send_text("move -1 1\n");
      write_gains(16'($urandom), 16'($urandom));
      send_text("move 1234 -4321\n");
   endtask

   // Stall the result side long enough to back up the input
   task automatic test_backpressure();
      feed_idle       = 1'b0;
      rsp_hold_cycles = 120;
      for (int i = 0; i < 12; i++) send_text((i % 2) ? "\n" : "move 1 2\n");
      wait_drained();
   endtask

   // Random lines with changing idle patterns and gain settings
   task automatic test_random_lines();
      int sent;
      int next_gain;
      sent      = 0;
      next_gain = 100;
      while (sent < 300) begin
         if ($urandom_range(0, 7) == 0) begin
            feed_idle  = $urandom_range(0, 2) != 0;
            drain_idle = $urandom_range(0, 2) != 0;
         end
         if (sent >= next_gain) begin
            write_gains(16'($urandom), 16'($urandom));
            next_gain += 100;
         end
         compose_random_line();
         sent += line_buf.size();
         send_line();
      end
   endtask

   // Main sequence
   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'd0;
      csr_write_enable = 1'b0;
      csr_index        = umcp_pkg::CSR_MOVE_GAIN;
      csr_write_data   = 16'd0;
      gain_move        = umcp_pkg::MOVE_GAIN_RESET;
      gain_turn        = umcp_pkg::TURN_GAIN_RESET;
      restart_line();
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_reset_gains();
      feed_idle  = 1'b1;
      drain_idle = 1'b1;
      test_syntax();
      test_zero_byte();
      test_long_lines();
      test_gain_settings();
      test_backpressure();
      test_random_lines();

      wait_drained();
      repeat (8) @(posedge clock);
      if (bad_results == 0)
         $display("tb_uart_move_command_parser OK");
      else
         $display("tb_uart_move_command_parser NOT OK");
      $finish;
   end

   // Result side: random gaps per item, plus long hold-offs on request
   initial begin
      bit took;
      int rsp_wait;
      rsp_wait      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         took = !reset && rsp_chan.valid && rsp_chan.ready;
         @(negedge clock);
         if (took) rsp_wait = drain_idle ? $urandom_range(0, 10) : 0;
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_chan.ready = 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   // Compare each accepted result with the oldest expectation
   move_result_type want;
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_lines.size() == 0) begin
            bad_results++;
            if (bad_results <= 10)
               $display("unexpected result: status %0d turn %0d move %0d",
                        rsp_chan.status, rsp_chan.turn_value, rsp_chan.move_value);
         end else begin
            want = expected_lines.pop_front();
            if (want.status !== rsp_chan.status ||
                want.turn_value !== rsp_chan.turn_value ||
                want.move_value !== rsp_chan.move_value ||
                want.turn_drive !== rsp_chan.turn_drive ||
                want.move_drive !== rsp_chan.move_drive) begin
               bad_results++;
               if (bad_results <= 10) begin
                  $display("result mismatch (expected/actual): status %0d/%0d turn %0d/%0d",
                           want.status, rsp_chan.status,
                           want.turn_value, rsp_chan.turn_value);
                  $display("   move %0d/%0d turn_drive %0d/%0d move_drive %0d/%0d",
                           want.move_value, rsp_chan.move_value,
                           want.turn_drive, rsp_chan.turn_drive,
                           want.move_drive, rsp_chan.move_drive);
               end
            end
         end
      end
   end

   // Run limit
   initial begin
      #3000000;
      $display("tb_uart_move_command_parser NOT OK");
      $finish;
   end

endmodule
